// File: design/fdd_pkg.sv
// fdd_pkg: shared constants, types and the cordic angle table for the
// fm discriminator / decimator. No dependencies.
package fdd_pkg;

  localparam int SAMPLE_BITS_DEFAULT   = 8;
  localparam int CORDIC_STAGES_DEFAULT = 16;
  localparam int CORDIC_STAGES_MAX     = 24;

  localparam int CFG_W     = 6;    // decim_factor, keep_every
  localparam int GAIN_W    = 16;   // audio_gain
  localparam int CFG_IDX_W = 2;
  localparam int AUDIO_W   = 16;

  // datapath widths of the cordic chain (scaled product sits in 33 bits)
  localparam int XW     = 35;
  localparam int ZW     = 34;
  localparam int CODE_W = 17;

  localparam logic [CFG_W-1:0]  DECIM_FACTOR_RESET = 6'd10;
  localparam logic [CFG_W-1:0]  KEEP_EVERY_RESET   = 6'd4;
  localparam logic [GAIN_W-1:0] AUDIO_GAIN_RESET   = 16'd30881;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIM_FACTOR = 2'd0,
    REG_KEEP_EVERY   = 2'd1,
    REG_AUDIO_GAIN   = 2'd2
  } cfg_reg_t;

  // one cordic slot handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 axis;      // product lies on the real axis
    logic                 axis_neg;  // real part negative
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-i), 2^31 means pi
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    begin
      case (idx)
        0:  v = 34'sd536870912;
        1:  v = 34'sd316933406;
        2:  v = 34'sd167458907;
        3:  v = 34'sd85004756;
        4:  v = 34'sd42667331;
        5:  v = 34'sd21354465;
        6:  v = 34'sd10679838;
        7:  v = 34'sd5340245;
        8:  v = 34'sd2670163;
        9:  v = 34'sd1335087;
        10: v = 34'sd667544;
        11: v = 34'sd333772;
        12: v = 34'sd166886;
        13: v = 34'sd83443;
        14: v = 34'sd41722;
        15: v = 34'sd20861;
        16: v = 34'sd10430;
        17: v = 34'sd5215;
        18: v = 34'sd2608;
        19: v = 34'sd1304;
        20: v = 34'sd652;
        21: v = 34'sd326;
        22: v = 34'sd163;
        23: v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: design/fdd_front.sv
// fdd_front: decimation counters, previous kept sample, conjugate product
// and cordic pre-rotation. Depends on fdd_pkg.
module fdd_front #(
  parameter int SAMPLE_BITS = fdd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_accept,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  input  logic [fdd_pkg::CFG_W-1:0]     decim_factor,
  input  logic [fdd_pkg::CFG_W-1:0]     keep_every,
  output fdd_pkg::cordic_t              cell_out
);
  import fdd_pkg::*;

  localparam int PW    = 2 * SAMPLE_BITS + 1;
  localparam int SHIFT = 32 - 2 * SAMPLE_BITS;
  localparam logic signed [ZW-1:0] Z_PI = ZW'(64'd1 << 31);

  logic [CFG_W-1:0] decim_count, decim_count_next;
  logic [CFG_W-1:0] keep_count, keep_count_next;
  logic [CFG_W-1:0] dlim, klim;
  logic [CFG_W:0]   decim_inc, keep_inc;
  logic signed [SAMPLE_BITS-1:0] prev_i, prev_q;
  logic keep, emit;

  logic signed [PW-1:0] re, im, re_next, im_next;
  logic                 prod_valid;

  logic signed [XW-1:0] xs, ys;
  cordic_t              cell_next;

  always_comb begin
    dlim = (decim_factor == '0) ? CFG_W'(1) : decim_factor;
    klim = (keep_every == '0) ? CFG_W'(1) : keep_every;
    keep = (decim_count == '0);
    emit = (keep_count == '0);
    decim_inc = {1'b0, decim_count} + (CFG_W+1)'(1);
    keep_inc  = {1'b0, keep_count} + (CFG_W+1)'(1);
    decim_count_next = (decim_inc >= {1'b0, dlim}) ? '0 : decim_inc[CFG_W-1:0];
    keep_count_next  = (keep_inc >= {1'b0, klim}) ? '0 : keep_inc[CFG_W-1:0];
    // current sample times conjugate of previous kept sample
    re_next = PW'(in_i * prev_i) + PW'(in_q * prev_q);
    im_next = PW'(in_q * prev_i) - PW'(in_i * prev_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decim_count <= '0;
      keep_count  <= '0;
      prev_i      <= '0;
      prev_q      <= '0;
    end else if (in_accept) begin
      decim_count <= decim_count_next;
      if (keep) begin
        prev_i     <= in_i;
        prev_q     <= in_q;
        keep_count <= keep_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      re <= re_next;
      im <= im_next;
    end
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv) begin
      prod_valid <= in_accept && keep && emit;
    end
  end

  // scale to full range and rotate into the right half plane
  always_comb begin
    xs = XW'(re) <<< SHIFT;
    ys = XW'(im) <<< SHIFT;
    cell_next.valid    = prod_valid;
    cell_next.axis     = (im == '0);
    cell_next.axis_neg = re[PW-1];
    if (re[PW-1]) begin
      cell_next.x = -xs;
      cell_next.y = -ys;
      cell_next.z = ys[XW-1] ? -Z_PI : Z_PI;
    end else begin
      cell_next.x = xs;
      cell_next.y = ys;
      cell_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (adv) begin
      cell_out.valid <= cell_next.valid;
    end
    if (adv) begin
      cell_out.axis     <= cell_next.axis;
      cell_out.axis_neg <= cell_next.axis_neg;
      cell_out.x        <= cell_next.x;
      cell_out.y        <= cell_next.y;
      cell_out.z        <= cell_next.z;
    end
  end

endmodule

// File: design/fdd_cordic_cell.sv
// fdd_cordic_cell: one registered vectoring step of the cordic chain.
// Depends on fdd_pkg.
module fdd_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  fdd_pkg::cordic_t cell_in,
  output fdd_pkg::cordic_t cell_out
);
  import fdd_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_entry(STAGE);

  logic signed [XW-1:0] xi, yi, dx, dy;
  logic signed [ZW-1:0] zi;
  cordic_t              cell_next;

  always_comb begin
    xi = cell_in.x;
    yi = cell_in.y;
    zi = cell_in.z;
    dx = yi >>> STAGE;
    dy = xi >>> STAGE;
    cell_next = cell_in;
    if (!yi[XW-1]) begin
      cell_next.x = xi + dx;
      cell_next.y = yi - dy;
      cell_next.z = zi + ATAN;
    end else begin
      cell_next.x = xi - dx;
      cell_next.y = yi + dy;
      cell_next.z = zi - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (adv) begin
      cell_out.valid <= cell_next.valid;
    end
    if (adv) begin
      cell_out.axis     <= cell_next.axis;
      cell_out.axis_neg <= cell_next.axis_neg;
      cell_out.x        <= cell_next.x;
      cell_out.y        <= cell_next.y;
      cell_out.z        <= cell_next.z;
    end
  end

endmodule

// File: design/fdd_scale.sv
// fdd_scale: angle rounding, gain multiply, rounding and saturation to
// q1.15 audio. Depends on fdd_pkg.
module fdd_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  fdd_pkg::cordic_t                  cell_in,
  input  logic [fdd_pkg::GAIN_W-1:0]        audio_gain,
  output logic                              out_valid,
  output logic signed [fdd_pkg::AUDIO_W-1:0] out_sample
);
  import fdd_pkg::*;

  localparam int PRODW = CODE_W + GAIN_W + 1;
  localparam logic signed [ZW-1:0]    CODE_MAX = ZW'(32768);
  localparam logic signed [ZW-1:0]    CODE_MIN = -CODE_MAX;
  localparam logic signed [PRODW-1:0] HALF     = PRODW'(32768);
  localparam logic signed [PRODW-1:0] AUD_MAX  = PRODW'(32767);
  localparam logic signed [PRODW-1:0] AUD_MIN  = PRODW'(-32768);

  logic signed [ZW-1:0]     zi, zr, zs;
  logic signed [CODE_W-1:0] code, code_next;
  logic                     code_valid;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PRODW-1:0]  prod, prod_next, rnd;

  always_comb begin
    zi = cell_in.z;
    zr = zi + ZW'(32768);
    zs = zr >>> 16;
    if (cell_in.axis) begin
      code_next = cell_in.axis_neg ? CODE_W'(32768) : '0;
    end else if (zs > CODE_MAX) begin
      code_next = CODE_W'(CODE_MAX);
    end else if (zs < CODE_MIN) begin
      code_next = CODE_W'(CODE_MIN);
    end else begin
      code_next = CODE_W'(zs);
    end
  end

  always_comb begin
    gain_s    = $signed({1'b0, audio_gain});
    prod_next = PRODW'(code) * PRODW'(gain_s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code <= code_next;
      prod <= prod_next;
    end
    if (rst) begin
      code_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      code_valid <= cell_in.valid;
      out_valid  <= code_valid;
    end
  end

  always_comb begin
    rnd = (prod + HALF) >>> 16;
    if (rnd > AUD_MAX) begin
      out_sample = AUDIO_W'(AUD_MAX);
    end else if (rnd < AUD_MIN) begin
      out_sample = AUDIO_W'(AUD_MIN);
    end else begin
      out_sample = AUDIO_W'(rnd);
    end
  end

endmodule

// File: design/fm_discriminator_decimator_top.sv
// fm_discriminator_decimator_top: fm quadrature demodulator with input
// decimation and audio rate reduction. Depends on fdd_pkg, fdd_front,
// fdd_cordic_cell and fdd_scale.
//
// One i/q sample is taken per clock on the s_axis side, with no gaps needed
// between transactions. One sample in decim_factor is kept and multiplied by
// the conjugate of the previous kept sample (the first previous sample is
// zero); the phase of that product is found by a chain of CORDIC_STAGES
// cordic cells, one vectoring step per cell per clock, as an angle code in
// which 32768 means pi. Every keep_every-th demodulated value is scaled by
// audio_gain (unsigned q0.16), rounded half up and saturated, and leaves on
// m_axis as a signed q1.15 sample. Throughput is one input per clock while
// s_axis_tready is high, set by the fully pipelined cordic chain. A
// two-entry output buffer lets the pipeline keep taking input while one
// result waits; s_axis_tready drops only when both entries are full, and
// then the whole pipeline holds. Configuration writes take effect at once
// and should be made while no samples are in flight. decim_factor or
// keep_every of zero acts as one.
module fm_discriminator_decimator_top #(
  parameter int SAMPLE_BITS   = fdd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int CORDIC_STAGES = fdd_pkg::CORDIC_STAGES_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input samples
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_i [SAMPLE_BITS-1:0], sample_q above it, zero padded to bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // audio output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // audio_sample [15:0]
  output logic [fdd_pkg::AUDIO_W-1:0]          m_axis_tdata,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [fdd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fdd_pkg::GAIN_W-1:0]           cfg_data
);
  import fdd_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]  decim_factor;
  logic [CFG_W-1:0]  keep_every;
  logic [GAIN_W-1:0] audio_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      decim_factor <= DECIM_FACTOR_RESET;
      keep_every   <= KEEP_EVERY_RESET;
      audio_gain   <= AUDIO_GAIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DECIM_FACTOR: decim_factor <= cfg_data[CFG_W-1:0];
        REG_KEEP_EVERY:   keep_every   <= cfg_data[CFG_W-1:0];
        REG_AUDIO_GAIN:   audio_gain   <= cfg_data;
        default:          ;  // unmapped index, ignored
      endcase
    end
  end

  // global pipeline advance: the output buffer still has a free entry
  logic [1:0] buf_count;
  logic       adv;
  logic       in_accept;

  assign adv           = (buf_count != 2'd2);
  assign s_axis_tready = adv;
  assign in_accept     = s_axis_tvalid && adv;

  // front end: decimation, conjugate product, pre-rotation
  cordic_t chain [0:CORDIC_STAGES];

  fdd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_accept    (in_accept),
    .in_i         ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .in_q         ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .decim_factor (decim_factor),
    .keep_every   (keep_every),
    .cell_out     (chain[0])
  );

  // row of cordic cells, one vectoring step each
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    fdd_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  // angle code to audio
  logic                      res_valid;
  logic signed [AUDIO_W-1:0] res_sample;

  fdd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .cell_in    (chain[CORDIC_STAGES]),
    .audio_gain (audio_gain),
    .out_valid  (res_valid),
    .out_sample (res_sample)
  );

  // two-entry output buffer, buf0 is the head
  logic [AUDIO_W-1:0] buf0, buf1;
  logic               push, pop;

  assign push          = adv && res_valid;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (buf_count != 2'd0);
  assign m_axis_tdata  = buf0;

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (buf_count == 2'd0) begin
          buf0 <= res_sample;
        end else begin
          buf1 <= res_sample;
        end
      end
      2'b01: begin
        buf0 <= buf1;
      end
      2'b11: begin
        if (buf_count == 2'd1) begin
          buf0 <= res_sample;
        end else begin
          buf0 <= buf1;
          buf1 <= res_sample;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 2'd0;
    end else if (push && !pop) begin
      buf_count <= buf_count + 2'd1;
    end else if (pop && !push) begin
      buf_count <= buf_count - 2'd1;
    end
  end

endmodule
